### hdl/sliding_window_frame_parser_assert.svh
// Assertion macros for the sliding window frame parser.
`ifndef SLIDING_WINDOW_FRAME_PARSER_ASSERT_SVH
`define SLIDING_WINDOW_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SWFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("swfp assertion failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define SWFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("swfp assertion failed");

`endif

### hdl/swfp_pkg.sv
package swfp_pkg;

    localparam int FRAME_BYTES = 19;
    localparam int CNT_W       = 5;
    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    typedef logic [7:0] byte_t;
    typedef logic [FRAME_BYTES-1:0][7:0] window_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef struct packed {
        logic full;
        logic hit;
    } win_ctrl_t;

    typedef struct packed {
        logic [7:0]         seq_index;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [7:0]         motion_intent;
        logic [7:0]         motion_request;
    } frame_t;

endpackage

### hdl/swfp_window.sv
module swfp_window (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  swfp_pkg::byte_t  rx_byte,
    input  logic             hit,
    output swfp_pkg::window_t win_next,
    output logic             full_next,
    output swfp_pkg::count_t fill_count
);
    import swfp_pkg::*;

    window_t win_reg;
    count_t  count_reg;
    count_t  count_next;

    // Shift in at the top; once full, the window holds the last bytes in order.
    assign win_next   = {rx_byte, win_reg[FRAME_BYTES-1:1]};
    assign full_next  = (count_reg >= count_t'(FRAME_BYTES - 1));
    assign fill_count = count_reg;

    always_comb begin
        priority if (hit) begin
            count_next = '0;
        end else if (full_next) begin
            count_next = count_t'(FRAME_BYTES);
        end else begin
            count_next = count_reg + count_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

endmodule

### hdl/swfp_frame_check.sv
module swfp_frame_check (
    input  swfp_pkg::window_t win,
    input  logic              full,
    output logic              hit,
    output swfp_pkg::frame_t  frame
);
    import swfp_pkg::*;

    byte_t s1 [8];
    byte_t s2 [4];
    byte_t s3 [2];
    byte_t sum;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            s1[i] = win[2 + 2*i] + win[3 + 2*i];
        end
        for (int i = 0; i < 4; i++) begin
            s2[i] = s1[2*i] + s1[2*i + 1];
        end
        for (int i = 0; i < 2; i++) begin
            s3[i] = s2[2*i] + s2[2*i + 1];
        end
        sum = s3[0] + s3[1];
    end

    assign hit = full && (win[0] == SYNC_BYTE) && (win[1] == SYNC_BYTE)
               && (sum == win[FRAME_BYTES-1]);

    always_comb begin
        frame.seq_index      = win[2];
        frame.yaw            = {win[4], win[3]};
        frame.pitch          = {win[6], win[5]};
        frame.roll           = {win[8], win[7]};
        frame.accel_x        = {win[10], win[9]};
        frame.accel_y        = {win[12], win[11]};
        frame.accel_z        = {win[14], win[13]};
        frame.motion_intent  = win[15];
        frame.motion_request = win[16];
    end

endmodule

### hdl/sliding_window_frame_parser.sv
// Output: a frame result is registered and valid in the cycle after its completing byte beat.
// Throughput: one byte beat per cycle; the input stalls only while a result
// waits in the output register and m_ready is low.
// Reset: synchronous, active low; clears the fill count and output valid.
// Window contents are not reset and are read only after 19 fresh bytes.
`include "sliding_window_frame_parser_assert.svh"

module sliding_window_frame_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic [31:0]        s_time_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_seq_index,
    output logic signed [15:0] m_yaw,
    output logic signed [15:0] m_pitch,
    output logic signed [15:0] m_roll,
    output logic signed [15:0] m_accel_x,
    output logic signed [15:0] m_accel_y,
    output logic signed [15:0] m_accel_z,
    output logic [7:0]         m_motion_intent,
    output logic [7:0]         m_motion_request,
    output logic [31:0]        m_stamp_us
);
    import swfp_pkg::*;

    logic      accept;
    window_t   win_next;
    count_t    fill_count;
    win_ctrl_t ctrl;
    frame_t    frame;
    frame_t    frame_reg;
    logic [31:0] stamp_reg;
    logic      m_valid_reg;
    logic      m_valid_next;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    swfp_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .rx_byte    (s_rx_byte),
        .hit        (ctrl.hit),
        .win_next   (win_next),
        .full_next  (ctrl.full),
        .fill_count (fill_count)
    );

    swfp_frame_check u_check (
        .win   (win_next),
        .full  (ctrl.full),
        .hit   (ctrl.hit),
        .frame (frame)
    );

    always_comb begin
        priority if (accept) begin
            m_valid_next = ctrl.hit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && ctrl.hit) begin
            frame_reg <= frame;
            stamp_reg <= s_time_us;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_seq_index      = frame_reg.seq_index;
    assign m_yaw            = frame_reg.yaw;
    assign m_pitch          = frame_reg.pitch;
    assign m_roll           = frame_reg.roll;
    assign m_accel_x        = frame_reg.accel_x;
    assign m_accel_y        = frame_reg.accel_y;
    assign m_accel_z        = frame_reg.accel_z;
    assign m_motion_intent  = frame_reg.motion_intent;
    assign m_motion_request = frame_reg.motion_request;
    assign m_stamp_us       = stamp_reg;

    `SWFP_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready)
    `SWFP_ASSERT_NOW(a_count_bound, 1'b1, fill_count <= count_t'(FRAME_BYTES))
    `SWFP_ASSERT_NEXT(a_empty_after_frame, accept && ctrl.hit, fill_count == '0 && m_valid)
    `SWFP_ASSERT_NOW(a_hit_needs_full, ctrl.hit, fill_count >= count_t'(FRAME_BYTES - 1))

endmodule

### dv/swfp_frame_checker.sv
module swfp_frame_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic [31:0]        s_time_us,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_seq_index,
    input  logic signed [15:0] m_yaw,
    input  logic signed [15:0] m_pitch,
    input  logic signed [15:0] m_roll,
    input  logic signed [15:0] m_accel_x,
    input  logic signed [15:0] m_accel_y,
    input  logic signed [15:0] m_accel_z,
    input  logic [7:0]         m_motion_intent,
    input  logic [7:0]         m_motion_request,
    input  logic [31:0]        m_stamp_us,
    output int                 fail_count,
    output int                 pending,
    output int                 bytes_seen,
    output int                 frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import swfp_pkg::*;

    typedef struct packed {
        frame_t      fields;
        logic [31:0] stamp;
    } parsed_frame_t;

    byte_t         win [FRAME_BYTES];
    count_t        fill;
    parsed_frame_t frames_due [$];

    initial begin
        fail_count  = 0;
        pending     = 0;
        bytes_seen  = 0;
        frames_seen = 0;
        fill        = '0;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            flag_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    task automatic absorb_byte(input byte_t rx, input logic [31:0] now);
        byte_t         sum;
        parsed_frame_t pf;
        if (fill == count_t'(FRAME_BYTES)) begin
            for (int k = 0; k < FRAME_BYTES - 1; k++) begin
                win[k] = win[k + 1];
            end
            win[FRAME_BYTES - 1] = rx;
        end else begin
            win[fill] = rx;
            fill      = fill + 1'b1;
        end
        if (fill == count_t'(FRAME_BYTES) && win[0] == SYNC_BYTE && win[1] == SYNC_BYTE) begin
            sum = '0;
            for (int k = 2; k < FRAME_BYTES - 1; k++) begin
                sum = sum + win[k];
            end
            if (sum == win[FRAME_BYTES - 1]) begin
                pf.fields.seq_index      = win[2];
                pf.fields.yaw            = {win[4], win[3]};
                pf.fields.pitch          = {win[6], win[5]};
                pf.fields.roll           = {win[8], win[7]};
                pf.fields.accel_x        = {win[10], win[9]};
                pf.fields.accel_y        = {win[12], win[11]};
                pf.fields.accel_z        = {win[14], win[13]};
                pf.fields.motion_intent  = win[15];
                pf.fields.motion_request = win[16];
                pf.stamp                 = now;
                frames_due.push_back(pf);
                fill = '0;
            end
        end
    endtask

    always @(posedge aclk) begin
        parsed_frame_t want;
        if (!aresetn) begin
            fill = '0;
            frames_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                frames_seen++;
                if (frames_due.size() == 0) begin
                    flag_mismatch("result beat with no frame due");
                end else begin
                    want = frames_due.pop_front();
                    check_field("seq_index", 32'(m_seq_index),
                                32'(want.fields.seq_index));
                    check_field("yaw", 32'(m_yaw), 32'(want.fields.yaw));
                    check_field("pitch", 32'(m_pitch), 32'(want.fields.pitch));
                    check_field("roll", 32'(m_roll), 32'(want.fields.roll));
                    check_field("accel_x", 32'(m_accel_x), 32'(want.fields.accel_x));
                    check_field("accel_y", 32'(m_accel_y), 32'(want.fields.accel_y));
                    check_field("accel_z", 32'(m_accel_z), 32'(want.fields.accel_z));
                    check_field("motion_intent", 32'(m_motion_intent),
                                32'(want.fields.motion_intent));
                    check_field("motion_request", 32'(m_motion_request),
                                32'(want.fields.motion_request));
                    check_field("stamp_us", m_stamp_us, want.stamp);
                end
            end
            if (s_valid && s_ready) begin
                bytes_seen++;
                absorb_byte(s_rx_byte, s_time_us);
            end
        end
        pending = frames_due.size();
    end

endmodule

### dv/tb_sliding_window_frame_parser.sv
module tb_sliding_window_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import swfp_pkg::*;

    localparam int PHASE_BYTES = 540;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = '0;
    logic [31:0]        s_time_us = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [7:0]         m_seq_index;
    logic signed [15:0] m_yaw;
    logic signed [15:0] m_pitch;
    logic signed [15:0] m_roll;
    logic signed [15:0] m_accel_x;
    logic signed [15:0] m_accel_y;
    logic signed [15:0] m_accel_z;
    logic [7:0]         m_motion_intent;
    logic [7:0]         m_motion_request;
    logic [31:0]        m_stamp_us;

    int    fail_count;
    int    pending;
    int    bytes_seen;
    int    frames_seen;
    int    sender_idle   = 0;
    int    receiver_idle = 0;
    int    bytes_sent    = 0;
    byte_t frame_body [16];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sliding_window_frame_parser uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_time_us        (s_time_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_seq_index      (m_seq_index),
        .m_yaw            (m_yaw),
        .m_pitch          (m_pitch),
        .m_roll           (m_roll),
        .m_accel_x        (m_accel_x),
        .m_accel_y        (m_accel_y),
        .m_accel_z        (m_accel_z),
        .m_motion_intent  (m_motion_intent),
        .m_motion_request (m_motion_request),
        .m_stamp_us       (m_stamp_us)
    );

    swfp_frame_checker frame_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_time_us        (s_time_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_seq_index      (m_seq_index),
        .m_yaw            (m_yaw),
        .m_pitch          (m_pitch),
        .m_roll           (m_roll),
        .m_accel_x        (m_accel_x),
        .m_accel_y        (m_accel_y),
        .m_accel_z        (m_accel_z),
        .m_motion_intent  (m_motion_intent),
        .m_motion_request (m_motion_request),
        .m_stamp_us       (m_stamp_us),
        .fail_count       (fail_count),
        .pending          (pending),
        .bytes_seen       (bytes_seen),
        .frames_seen      (frames_seen)
    );

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end

    task automatic send_byte(input byte_t rx, input logic [31:0] now);
        while ($urandom_range(0, 99) < sender_idle) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        s_time_us <= now;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    task automatic send_frame(input bit bad_sum, input logic [31:0] last_time);
        byte_t sum;
        sum = '0;
        for (int k = 0; k < 16; k++) begin
            sum = sum + frame_body[k];
        end
        if (bad_sum) begin
            sum = sum + byte_t'($urandom_range(1, 255));
        end
        send_byte(SYNC_BYTE, $urandom);
        send_byte(SYNC_BYTE, $urandom);
        for (int k = 0; k < 16; k++) begin
            send_byte(frame_body[k], $urandom);
        end
        send_byte(sum, last_time);
    endtask

    task automatic drain_frames();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int kind;
        int burst;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // header into a window that is not yet full
        send_byte(SYNC_BYTE, 32'h0);
        send_byte(SYNC_BYTE, 32'h1);
        send_byte(8'h00, 32'h2);

        frame_body = '{8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF,
                       8'hFF, 8'h01, 8'h00, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h5A};
        send_frame(1'b0, 32'hFFFF_FFFF);

        frame_body = '{default: 8'h00};
        send_frame(1'b1, 32'h1234_5678);

        frame_body = '{SYNC_BYTE, SYNC_BYTE, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                       8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E};
        send_frame(1'b0, 32'h0);
        drain_frames();

        for (int phase = 0; phase < 3; phase++) begin
            unique case (phase)
                0: begin
                    sender_idle   = 19;
                    receiver_idle = 49;
                end
                1: begin
                    sender_idle   = 49;
                    receiver_idle = 19;
                end
                default: begin
                    sender_idle   = 0;
                    receiver_idle = 0;
                end
            endcase
            while (bytes_sent < (phase + 1) * PHASE_BYTES) begin
                kind = $urandom_range(0, 9);
                for (int k = 0; k < 16; k++) begin
                    frame_body[k] = byte_t'($urandom);
                end
                if (kind == 8) begin
                    frame_body[0] = SYNC_BYTE;
                    frame_body[1] = SYNC_BYTE;
                end
                if (kind <= 5 || kind == 8) begin
                    send_frame(1'b0, $urandom);
                end else if (kind == 6) begin
                    send_frame(1'b1, $urandom);
                end else if (kind == 7) begin
                    burst = $urandom_range(1, 8);
                    repeat (burst) begin
                        send_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : byte_t'($urandom),
                                  $urandom);
                    end
                end else begin
                    send_byte(SYNC_BYTE, $urandom);
                    send_byte(SYNC_BYTE, $urandom);
                    burst = $urandom_range(0, 12);
                    repeat (burst) begin
                        send_byte(byte_t'($urandom), $urandom);
                    end
                end
            end
            drain_frames();
        end

        repeat (8) @(posedge aclk);
        $display("covered %0d byte beats and %0d decoded frames", bytes_seen, frames_seen);
        $display("mixed good, corrupted, truncated and overlapping frames under three stall mixes");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("timeout with %0d frames outstanding", pending);
        $display("status: fail");
        $finish;
    end

endmodule
